// ===== rtl/core/ees_pkg.sv =====
// Shared types, widths and helpers for the element stiffness core.
// No dependencies; every other file in rtl/core but ees_ram imports this package.
package ees_pkg;

    localparam int GRAD_W    = 18;   // Q6.12 gradient
    localparam int WGT_W     = 18;   // Q6.12 weight
    localparam int CFG_W     = 32;   // widest register
    localparam int PROD_W    = 24;   // gradient product after truncation
    localparam int DOT_W     = 26;   // sum of three gradient products
    localparam int LM_W      = 45;   // lambda / mu term
    localparam int DTERM_W   = 47;   // dot term
    localparam int T_W       = 48;   // summed pair term before weighting
    localparam int PH_W      = 55;   // term times integer part of weight
    localparam int PL_W      = 49;   // term times fraction of weight, truncated
    localparam int CONTRIB_W = 56;   // weighted contribution
    localparam int ACC_W     = 48;   // Q36.12 accumulator
    localparam int SUM_W     = 58;   // accumulator plus contribution
    localparam int WORD_W    = ACC_W + 1;  // stored entry: flag and value

    // Register indexes
    localparam logic [1:0] REG_LAMBDA = 2'd0;
    localparam logic [1:0] REG_MU     = 2'd1;
    localparam logic [1:0] REG_DOFS   = 2'd2;
    localparam logic [1:0] REG_POINTS = 2'd3;

    // Component codes
    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic [1:0]               comp;
        logic signed [GRAD_W-1:0] gz;
        logic signed [GRAD_W-1:0] gy;
        logic signed [GRAD_W-1:0] gx;
    } dof_entry_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // Gradient entry selected by a component code; codes past the
    // dimension read as zero.
    function automatic logic signed [GRAD_W-1:0] grad_at(dof_entry_t e, logic [1:0] c,
                                                         int dim);
        logic signed [GRAD_W-1:0] g;
        g = '0;
        case (c)
            COMP_X: g = e.gx;
            COMP_Y: g = e.gy;
            COMP_Z: g = (dim >= 3) ? e.gz : '0;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/core/elastic_element_stiffness_core.sv =====
// Top level of the element stiffness core: dof ring, pair pipeline, matrix store.
// Depends on ees_pkg, ees_cell, ees_pair_unit and ees_ram.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   cfg     | in        | cfg_wr_en          | cfg_index, cfg_wdata
//   s_      | in        | s_valid / s_ready  | component, grad_x/y/z, weight
//   m_      | out       | m_valid / m_ready  | row, col, value, saturated, last
//
// For each item the ring rotates once and the pair pipeline then drains;
// the ring walks every stored dof past one shared pair pipeline.
// The last item of an element starts emission: each entry steps through a read,
// a load and a wait for m_ready, the matrix RAM read being registered.
// Reset is synchronous; the matrix clears at once through per-entry valid bits.
// s_ready is low from an accepted transfer until its work and any emission end.
module elastic_element_stiffness_core import ees_pkg::*; #(
    parameter int MAX_DOFS  = 8,
    parameter int DIMENSION = 2
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [1:0]               cfg_index,
    input  logic [CFG_W-1:0]         cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_component,
    input  logic signed [GRAD_W-1:0] s_grad_x,
    input  logic signed [GRAD_W-1:0] s_grad_y,
    input  logic signed [GRAD_W-1:0] s_grad_z,
    input  logic [WGT_W-1:0]         s_weight,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [2:0]               m_row,
    output logic [2:0]               m_col,
    output logic signed [ACC_W-1:0]  m_value,
    output logic                     m_saturated,
    output logic                     m_last
);

    localparam int DOF_W   = (MAX_DOFS > 1) ? $clog2(MAX_DOFS) : 1;
    localparam int CNT_W   = $clog2(MAX_DOFS + 1);
    localparam int ADDR_W  = 2 * DOF_W;
    localparam int ENTRIES = 2 ** ADDR_W;

    localparam logic signed [SUM_W-1:0] SUM_HI = {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
    localparam logic [ACC_W-1:0] ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PROC  = 6'b000010,
        ST_DRAIN = 6'b000100,
        ST_EMRD  = 6'b001000,
        ST_EMLD  = 6'b010000,
        ST_EMWT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [CFG_W-1:0] lambda_reg, mu_reg;
    logic [3:0]       dofs_reg;
    logic [6:0]       points_reg;
    logic [CNT_W-1:0] n_eff;
    logic [6:0]       q_eff;

    // sequencing
    logic [DOF_W-1:0] dof_cnt_reg, d_reg, rot_cnt_reg;
    logic [5:0]       pt_cnt_reg;
    logic             emit_reg;
    dof_entry_t       gi_reg, in_entry;
    logic [WGT_W-1:0] w_reg;
    logic             in_xfer, out_xfer;
    logic             dof_wrap, pt_wrap;

    // ring
    dof_entry_t ring_q [MAX_DOFS];
    cell_ctrl_t cell_ctrl [MAX_DOFS];
    logic       pair_issue;

    // pipeline and store
    logic                        pu_valid, pu_busy;
    logic [ADDR_W-1:0]           pu_addr;
    logic signed [CONTRIB_W-1:0] pu_contrib;
    logic                        acc_vld_reg;
    logic [ADDR_W-1:0]           acc_addr_reg;
    logic signed [CONTRIB_W-1:0] acc_contrib_reg;
    logic [ENTRIES-1:0]          ent_vld_reg;
    logic                        vld_rd_reg;
    logic [ADDR_W-1:0]           rd_addr, em_addr;
    logic [WORD_W-1:0]           rd_data, wr_data;
    logic signed [ACC_W-1:0]     old_val;
    logic signed [SUM_W-1:0]     sum;

    // emission
    logic [DOF_W-1:0] em_row_reg, em_col_reg;
    logic             em_last;
    logic             m_valid_reg, m_sat_reg, m_last_reg;
    logic [2:0]       m_row_reg, m_col_reg;
    logic [ACC_W-1:0] m_value_reg;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid_reg && m_ready;

    // Clamp the counts to their legal ranges.
    always_comb begin
        if (dofs_reg == 4'd0) begin
            n_eff = CNT_W'(1);
        end else if (32'(dofs_reg) > MAX_DOFS) begin
            n_eff = CNT_W'(MAX_DOFS);
        end else begin
            n_eff = CNT_W'(dofs_reg);
        end
        if (points_reg == 7'd0) begin
            q_eff = 7'd1;
        end else if (points_reg > 7'd64) begin
            q_eff = 7'd64;
        end else begin
            q_eff = points_reg;
        end
    end

    assign dof_wrap = !((CNT_W'(dof_cnt_reg) + CNT_W'(1)) < n_eff);
    assign pt_wrap  = !((7'(pt_cnt_reg) + 7'd1) < q_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lambda_reg <= '0;
            mu_reg     <= '0;
            dofs_reg   <= 4'd8;
            points_reg <= 7'd4;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LAMBDA: lambda_reg <= cfg_wdata;
                REG_MU:     mu_reg     <= cfg_wdata;
                REG_DOFS:   dofs_reg   <= cfg_wdata[3:0];
                REG_POINTS: points_reg <= cfg_wdata[6:0];
                default:    lambda_reg <= lambda_reg;
            endcase
        end
    end

    // Arriving dof; drop z in two dimensions so the dot term sees zero.
    assign in_entry.comp = s_component;
    assign in_entry.gx   = s_grad_x;
    assign in_entry.gy   = s_grad_y;
    assign in_entry.gz   = (DIMENSION >= 3) ? s_grad_z : '0;

    // Ring of cells: cell 0 is the head; entries move one place towards it.
    for (genvar k = 0; k < MAX_DOFS; k++) begin : g_ring
        assign cell_ctrl[k].load  = in_xfer && (dof_cnt_reg == DOF_W'(k));
        assign cell_ctrl[k].shift = (state_reg == ST_PROC);
        ees_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[k]),
            .load_data (in_entry),
            .shift_in  (ring_q[(k + 1) % MAX_DOFS]),
            .data_out  (ring_q[k])
        );
    end

    // The head holds dof rot_cnt; pair it with the arriving dof up to itself.
    assign pair_issue = (state_reg == ST_PROC) && (rot_cnt_reg <= d_reg);

    ees_pair_unit #(
        .ADDR_W    (ADDR_W),
        .DIMENSION (DIMENSION)
    ) u_pair (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (pair_issue),
        .in_addr      ({d_reg, rot_cnt_reg}),
        .gi           (gi_reg),
        .gj           (ring_q[0]),
        .weight       (w_reg),
        .lambda_value (lambda_reg),
        .mu_value     (mu_reg),
        .out_valid    (pu_valid),
        .out_addr     (pu_addr),
        .out_contrib  (pu_contrib),
        .busy         (pu_busy)
    );

    // Only the lower triangle is stored; read the mirror for upper entries.
    assign em_addr = (em_row_reg >= em_col_reg) ? {em_row_reg, em_col_reg}
                                                : {em_col_reg, em_row_reg};
    assign rd_addr = (state_reg == ST_EMRD) ? em_addr : pu_addr;

    // Read-modify-write with saturation; an entry never written reads as zero.
    assign old_val = vld_rd_reg ? $signed(rd_data[ACC_W-1:0]) : '0;
    assign sum     = SUM_W'(old_val) + SUM_W'(acc_contrib_reg);

    always_comb begin
        if (sum > SUM_HI) begin
            wr_data = {1'b1, ACC_HI};
        end else if (sum < SUM_LO) begin
            wr_data = {1'b1, ACC_LO};
        end else begin
            wr_data = {vld_rd_reg && rd_data[ACC_W], sum[ACC_W-1:0]};
        end
    end

    ees_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (acc_vld_reg),
        .wr_addr (acc_addr_reg),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign em_last = (CNT_W'(em_row_reg) + CNT_W'(1) == n_eff)
                  && (CNT_W'(em_col_reg) + CNT_W'(1) == n_eff);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_xfer) state_next = ST_PROC;
            ST_PROC:  if (rot_cnt_reg == DOF_W'(MAX_DOFS - 1)) state_next = ST_DRAIN;
            ST_DRAIN: begin
                if (!pu_busy && !acc_vld_reg) begin
                    state_next = emit_reg ? ST_EMRD : ST_IDLE;
                end
            end
            ST_EMRD:  state_next = ST_EMLD;
            ST_EMLD:  state_next = ST_EMWT;
            ST_EMWT: begin
                if (out_xfer) begin
                    state_next = m_last_reg ? ST_IDLE : ST_EMRD;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dof_cnt_reg <= '0;
            pt_cnt_reg  <= '0;
            emit_reg    <= 1'b0;
            rot_cnt_reg <= '0;
            em_row_reg  <= '0;
            em_col_reg  <= '0;
            acc_vld_reg <= 1'b0;
            ent_vld_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_vld_reg <= pu_valid;
            if (acc_vld_reg) begin
                ent_vld_reg[acc_addr_reg] <= 1'b1;
            end
            // Advance the dof and point counters as the transfer lands.
            if (in_xfer) begin
                rot_cnt_reg <= '0;
                emit_reg    <= dof_wrap && pt_wrap;
                if (!dof_wrap) begin
                    dof_cnt_reg <= dof_cnt_reg + DOF_W'(1);
                end else begin
                    dof_cnt_reg <= '0;
                    pt_cnt_reg  <= pt_wrap ? 6'd0 : pt_cnt_reg + 6'd1;
                end
            end
            if (state_reg == ST_PROC) begin
                rot_cnt_reg <= rot_cnt_reg + DOF_W'(1);
            end
            if (state_reg == ST_DRAIN) begin
                em_row_reg <= '0;
                em_col_reg <= '0;
            end
            if (state_reg == ST_EMLD) begin
                m_valid_reg <= 1'b1;
            end
            if (state_reg == ST_EMWT && out_xfer) begin
                m_valid_reg <= 1'b0;
                if (m_last_reg) begin
                    ent_vld_reg <= '0;   // clear the whole matrix
                end else if (CNT_W'(em_col_reg) + CNT_W'(1) == n_eff) begin
                    em_col_reg <= '0;
                    em_row_reg <= em_row_reg + DOF_W'(1);
                end else begin
                    em_col_reg <= em_col_reg + DOF_W'(1);
                end
            end
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            gi_reg <= in_entry;
            w_reg  <= s_weight;
            d_reg  <= dof_cnt_reg;
        end
        acc_addr_reg    <= pu_addr;
        acc_contrib_reg <= pu_contrib;
        vld_rd_reg      <= ent_vld_reg[rd_addr];
        if (state_reg == ST_EMLD) begin
            m_row_reg   <= 3'(em_row_reg);
            m_col_reg   <= 3'(em_col_reg);
            m_value_reg <= vld_rd_reg ? rd_data[ACC_W-1:0] : '0;
            m_sat_reg   <= vld_rd_reg && rd_data[ACC_W];
            m_last_reg  <= em_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_row       = m_row_reg;
    assign m_col       = m_col_reg;
    assign m_value     = $signed(m_value_reg);
    assign m_saturated = m_sat_reg;
    assign m_last      = m_last_reg;

    a_no_accept_while_emitting: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input accepted while a result is pending");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("block not idle after final entry");

    a_last_clears_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> (ent_vld_reg == '0))
        else $error("matrix not cleared after emission");

    a_no_write_in_emission: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMRD || state_reg == ST_EMLD || state_reg == ST_EMWT)
        |-> !acc_vld_reg && !pu_busy)
        else $error("store update during emission");

    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second transfer before work ended");

endmodule

// ===== rtl/core/ees_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ees_ram #(
    parameter int WIDTH = 49,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/ees_cell.sv =====
// One cell of the dof ring: holds one stored gradient and component.
// Depends on ees_pkg.
module ees_cell import ees_pkg::*; (
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  dof_entry_t load_data,
    input  dof_entry_t shift_in,
    output dof_entry_t data_out
);

    dof_entry_t data_reg;

    // Load has priority; hand on the neighbour's entry while the ring turns.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            data_reg <= load_data;
        end else if (ctrl.shift) begin
            data_reg <= shift_in;
        end
    end

    assign data_out = data_reg;

endmodule

// ===== rtl/core/ees_pair_unit.sv =====
// Five-stage pipeline computing the weighted stiffness contribution of a dof pair.
// Depends on ees_pkg.
module ees_pair_unit import ees_pkg::*; #(
    parameter int ADDR_W    = 6,
    parameter int DIMENSION = 2
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  logic [ADDR_W-1:0]           in_addr,
    input  dof_entry_t                  gi,
    input  dof_entry_t                  gj,
    input  logic [WGT_W-1:0]            weight,
    input  logic [CFG_W-1:0]            lambda_value,
    input  logic [CFG_W-1:0]            mu_value,
    output logic                        out_valid,
    output logic [ADDR_W-1:0]           out_addr,
    output logic signed [CONTRIB_W-1:0] out_contrib,
    output logic                        busy
);

    logic [4:0]        vld_reg;
    logic [ADDR_W-1:0] addr_reg [5];

    // stage 1: gradient products
    logic signed [GRAD_W-1:0]   a_i, a_j, b_i, b_j;
    logic signed [2*GRAD_W-1:0] prod_a, prod_b, prod_x, prod_y, prod_z;
    logic signed [DOT_W-1:0]    dot_next;
    logic signed [PROD_W-1:0]   pa_reg, pb_reg;
    logic signed [DOT_W-1:0]    dot_reg;
    logic                       eq_reg;

    // stage 2: material terms
    logic signed [PROD_W+CFG_W:0] l_full, m_full;
    logic signed [DOT_W+CFG_W:0]  d_full;
    logic signed [LM_W-1:0]       l_reg, m_reg;
    logic signed [DTERM_W-1:0]    d_reg;

    // stage 3 and 4: summed term and weighting
    logic signed [T_W-1:0]       t_reg;
    logic signed [T_W+WGT_W-12:0] ph_full;
    logic signed [T_W+12:0]      pl_full;
    logic signed [PH_W-1:0]      ph_reg;
    logic signed [PL_W-1:0]      pl_reg;
    logic signed [CONTRIB_W-1:0] contrib_reg;

    assign a_i = grad_at(gi, gi.comp, DIMENSION);
    assign a_j = grad_at(gj, gj.comp, DIMENSION);
    assign b_i = grad_at(gi, gj.comp, DIMENSION);
    assign b_j = grad_at(gj, gi.comp, DIMENSION);

    assign prod_a = a_i * a_j;
    assign prod_b = b_i * b_j;
    assign prod_x = gi.gx * gj.gx;
    assign prod_y = gi.gy * gj.gy;
    assign prod_z = gi.gz * gj.gz;   // stored z is zero in two dimensions

    // Sign-extend each truncated product before summing.
    assign dot_next = DOT_W'($signed(prod_x[2*GRAD_W-1:12]))
                    + DOT_W'($signed(prod_y[2*GRAD_W-1:12]))
                    + DOT_W'($signed(prod_z[2*GRAD_W-1:12]));

    assign l_full = pa_reg * $signed({1'b0, lambda_value});
    assign m_full = pb_reg * $signed({1'b0, mu_value});
    assign d_full = dot_reg * $signed({1'b0, mu_value});

    assign ph_full = t_reg * $signed({1'b0, weight[WGT_W-1:12]});
    assign pl_full = t_reg * $signed({1'b0, weight[11:0]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg[0] <= in_addr;
        for (int s = 1; s < 5; s++) begin
            addr_reg[s] <= addr_reg[s-1];
        end
        pa_reg      <= prod_a[2*GRAD_W-1:12];
        pb_reg      <= prod_b[2*GRAD_W-1:12];
        dot_reg     <= dot_next;
        eq_reg      <= (gi.comp == gj.comp);
        l_reg       <= l_full[PROD_W+CFG_W:12];
        m_reg       <= m_full[PROD_W+CFG_W:12];
        d_reg       <= eq_reg ? d_full[DOT_W+CFG_W:12] : '0;
        t_reg       <= T_W'(l_reg) + T_W'(m_reg) + T_W'(d_reg);
        ph_reg      <= ph_full;
        pl_reg      <= pl_full[T_W+12:12];
        contrib_reg <= CONTRIB_W'(ph_reg) + CONTRIB_W'(pl_reg);
    end

    assign out_valid   = vld_reg[4];
    assign out_addr    = addr_reg[4];
    assign out_contrib = contrib_reg;
    assign busy        = |vld_reg;

endmodule
